// ===== hdl/emt_pkg.sv =====
// shared types, constants and the thinning decision for the edge map thinning block
`timescale 1ns / 1ps
`default_nettype none

package emt_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int PIX_W         = 8;
  localparam int FW_W          = 11;
  localparam int FH_W          = 16;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;
  localparam int NB_W          = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // per-word control decided at the input side
  typedef struct packed {
    logic pix;       // raw pixel word, goes into the line buffer
    logic emit;      // word produces a result
    logic inner;     // result position is off the frame border
    logic last;      // result is the final pixel of the frame
    logic tail_row;  // result lies on the bottom row
  } emt_ctl_t;

  // neighbour flags, msb first: ul, up, ur, rt, dr, dn, dl, lf
  function automatic logic emt_thin_clear(input logic [NB_W-1:0] nb);
    logic       ul, n_up, ur, n_rt, dr, n_dn, dl, n_lf;
    logic       g1, g2, g3, g4;
    logic [2:0] adj, links, groups;
    begin
      {ul, n_up, ur, n_rt, dr, n_dn, dl, n_lf} = nb;
      g1 = ul | n_up;
      g2 = ur | n_rt;
      g3 = dr | n_dn;
      g4 = dl | n_lf;
      adj    = 3'(n_up) + 3'(n_rt) + 3'(n_dn) + 3'(n_lf);
      links  = 3'(n_up & g2) + 3'(n_rt & g3) + 3'(n_dn & g4) + 3'(n_lf & g1);
      groups = 3'(g1) + 3'(g2) + 3'(g3) + 3'(g4);
      return (adj > 3'd1) && ({1'b0, groups} < ({1'b0, links} + 4'd2));
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/edge_map_thinning.sv =====
// top level of the single pass 3x3 edge map thinning block
// Takes one word per clock, pixel words in raster order or flush words, and returns
// results at the same rate: a word is accepted whenever the result register is empty or
// being taken, and its result, if any, passes the stage-1 and result registers. Results
// lag the pixel stream by frame_width+1 pixels; after the last pixel of a frame, flush
// words (or further pixel words) drain the remaining frame_width+1 results, the final
// one marked by out_frame_last, after which the next pixel starts a new frame. Two line
// buffers of MAX_WIDTH entries, one raw and one of thinned flags, each read and written
// at most once per word, hold the rows around the pixel being judged. Writing either
// configuration register restarts the frame; write it only while no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module edge_map_thinning
  import emt_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_kind,
  input  wire logic [PIX_W-1:0]     in_pixel,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [PIX_W-1:0]     out_pixel,
  output logic                      out_frame_last
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  emt_ctl_t         ctl;
  logic [COL_W-1:0] raw_addr, up_addr, out_col;
  logic             en, take;

  // whole pipeline moves together; it only holds while a result waits
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign take     = in_valid && en;

  emt_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_kind   (in_kind),
    .take      (take),
    .ctl       (ctl),
    .raw_addr  (raw_addr),
    .up_addr   (up_addr),
    .out_col   (out_col)
  );

  emt_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .take           (take),
    .ctl            (ctl),
    .raw_addr       (raw_addr),
    .up_addr        (up_addr),
    .out_col        (out_col),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_pixel      (out_pixel),
    .out_frame_last (out_frame_last)
  );

endmodule

`default_nettype wire

// ===== hdl/emt_seq.sv =====
// frame geometry registers, raster counters and per-word control decode
`timescale 1ns / 1ps
`default_nettype none

module emt_seq
  import emt_pkg::*;
#(
  parameter int  MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W     = $clog2(MAX_WIDTH),
  localparam int EW_W      = $clog2(MAX_WIDTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_kind,
  input  wire logic                 take,
  output emt_ctl_t                  ctl,
  output logic      [COL_W-1:0]     raw_addr,
  output logic      [COL_W-1:0]     up_addr,
  output logic      [COL_W-1:0]     out_col
);

  localparam int WIDTH_RST_EFF = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  logic [COL_W-1:0] ic_r, ic_nxt, ox_r, ox_nxt;
  logic [FH_W-1:0]  ir_r, ir_nxt, oy_r, oy_nxt;
  logic [EW_W-1:0]  ew_r, ew_nxt;
  logic [FH_W-1:0]  eh_r, eh_nxt;
  logic             restart;
  int               fw_int;

  logic complete, pix, emit, col_end_in, col_end_out, row_end_out, inner, last;

  assign fw_int = int'(cfg_wdata[FW_W-1:0]);

  // config writes clamp the geometry and restart the frame
  always_comb begin
    ew_nxt  = ew_r;
    eh_nxt  = eh_r;
    restart = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          if (fw_int == 0) begin
            ew_nxt = EW_W'(1);
          end else if (fw_int > MAX_WIDTH) begin
            ew_nxt = EW_W'(MAX_WIDTH);
          end else begin
            ew_nxt = EW_W'(fw_int);
          end
          restart = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          eh_nxt  = (cfg_wdata[FH_W-1:0] == '0) ? FH_W'(1) : cfg_wdata[FH_W-1:0];
          restart = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  assign complete    = (ir_r == eh_r);
  assign pix         = !in_kind && !complete;
  // results start once a full row plus one pixel has gone in
  assign emit        = pix ? ((ir_r > FH_W'(1)) || ((ir_r == FH_W'(1)) && (ic_r != '0)))
                           : complete;
  assign col_end_in  = ((EW_W'(ic_r) + EW_W'(1)) == ew_r);
  assign col_end_out = ((EW_W'(ox_r) + EW_W'(1)) == ew_r);
  assign row_end_out = (({1'b0, oy_r} + 17'd1) == {1'b0, eh_r});
  assign last        = emit && col_end_out && row_end_out;
  assign inner       = (oy_r != '0) && (({1'b0, oy_r} + 17'd2) <= {1'b0, eh_r}) &&
                       (ox_r != '0) &&
                       (((EW_W + 1)'(ox_r) + (EW_W + 1)'(2)) <= (EW_W + 1)'(ew_r));

  assign ctl.pix      = pix;
  assign ctl.emit     = emit;
  assign ctl.inner    = inner;
  assign ctl.last     = last;
  assign ctl.tail_row = row_end_out;

  // flush words on the bottom row read their own pixel back from the line buffer
  assign raw_addr = pix ? ic_r : ox_r;
  assign up_addr  = col_end_out ? '0 : (ox_r + COL_W'(1));
  assign out_col  = ox_r;

  always_comb begin
    ic_nxt = ic_r;
    ir_nxt = ir_r;
    ox_nxt = ox_r;
    oy_nxt = oy_r;
    if (restart || (take && last)) begin
      ic_nxt = '0;
      ir_nxt = '0;
      ox_nxt = '0;
      oy_nxt = '0;
    end else if (take) begin
      if (pix) begin
        if (col_end_in) begin
          ic_nxt = '0;
          ir_nxt = ir_r + FH_W'(1);
        end else begin
          ic_nxt = ic_r + COL_W'(1);
        end
      end
      if (emit) begin
        if (col_end_out) begin
          ox_nxt = '0;
          oy_nxt = oy_r + FH_W'(1);
        end else begin
          ox_nxt = ox_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r <= '0;
      ir_r <= '0;
      ox_r <= '0;
      oy_r <= '0;
      ew_r <= EW_W'(WIDTH_RST_EFF);
      eh_r <= FH_W'(HEIGHT_RESET);
    end else begin
      ic_r <= ic_nxt;
      ir_r <= ir_nxt;
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      ew_r <= ew_nxt;
      eh_r <= eh_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/emt_window.sv =====
// line buffers, 3x3 neighbourhood registers, thinning decision and result register
`timescale 1ns / 1ps
`default_nettype none

module emt_window
  import emt_pkg::*;
#(
  parameter int  MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             take,
  input  emt_ctl_t              ctl,
  input  wire logic [COL_W-1:0] raw_addr,
  input  wire logic [COL_W-1:0] up_addr,
  input  wire logic [COL_W-1:0] out_col,
  input  wire logic [PIX_W-1:0] in_pixel,
  output logic                  out_valid,
  output logic      [PIX_W-1:0] out_pixel,
  output logic                  out_frame_last
);

  // raw previous row, and thinned flags of the row above the result
  logic [PIX_W-1:0] raw_mem [MAX_WIDTH];
  logic             up_mem  [MAX_WIDTH];

  logic             s1_valid_r, s1_valid_nxt;
  emt_ctl_t         s1_ctl_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic [PIX_W-1:0] rd_r, prev_rd_r, px1_r, px2_r;
  logic             trd_r, tr1_r, tr2_r, left_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_last_r;

  logic [PIX_W-1:0] self_pix, res_pix;
  logic [NB_W-1:0]  nb;
  logic             clear, thin, s1_emit;

  assign s1_valid_nxt = take && (ctl.pix || ctl.emit);
  assign s1_emit      = s1_valid_r && s1_ctl_r.emit;

  always_ff @(posedge clk) begin
    if (take && ctl.pix) begin
      raw_mem[raw_addr] <= in_pixel;
    end
    if (en) begin
      rd_r <= raw_mem[raw_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_emit) begin
      up_mem[s1_col_r] <= thin;
    end
    if (en) begin
      trd_r <= up_mem[up_addr];
    end
  end

  // the lower row and right neighbour are raw, the upper row and left are thinned
  assign self_pix = s1_ctl_r.tail_row ? rd_r : prev_rd_r;
  assign nb       = {tr2_r, tr1_r, trd_r, |rd_r, |s1_pix_r, |px1_r, |px2_r, left_r};
  assign clear    = s1_ctl_r.inner && emt_thin_clear(nb);
  assign res_pix  = clear ? '0 : self_pix;
  assign thin     = |res_pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctl_r    <= ctl;
      s1_pix_r    <= in_pixel;
      s1_col_r    <= out_col;
      out_pixel_r <= res_pix;
      out_last_r  <= s1_ctl_r.last;
      if (s1_valid_r && s1_ctl_r.pix) begin
        prev_rd_r <= rd_r;
        px1_r     <= s1_pix_r;
        px2_r     <= px1_r;
      end
      if (s1_emit) begin
        tr1_r  <= trd_r;
        tr2_r  <= tr1_r;
        left_r <= thin;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel      = out_pixel_r;
  assign out_frame_last = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/emt_chk.sv =====
// port level checker for the edge map thinning block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module emt_chk
  import emt_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [PIX_W-1:0] out_pixel,
  input wire logic             out_frame_last
);

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel) && $stable(out_frame_last))
    else $error("stalled result word changed");

  // input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // a fresh result comes from an accepted word, through the stage-1 and result registers
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without an accepted word");

endmodule

bind edge_map_thinning emt_chk u_emt_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pixel      (out_pixel),
  .out_frame_last (out_frame_last)
);

`default_nettype wire
